// ----- rtl/core/slsps_pkg.sv -----
`timescale 1ns / 1ps

package slsps_pkg;

    localparam int FACTOR_W = 17;
    localparam int SCORE_W  = 18;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd32768;

    // register select: bit 2 of the byte address
    localparam logic REG_FACTOR_SEL = 1'b0;

    typedef enum logic [2:0] {
        CMD_EQ   = 3'd0,
        CMD_NEQ  = 3'd1,
        CMD_ULT  = 3'd2,
        CMD_UGE  = 3'd3,
        CMD_AND  = 3'd4,
        CMD_OR   = 3'd5,
        CMD_LEAF = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic eval;
        logic scan;
        logic div_start;
        logic div_capture;
        logic out_load;
    } t_ctrl;

endpackage

// ----- rtl/core/slsps_divider.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module slsps_divider #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        fits  = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= CNT_W'(DIVIDEND_W - 1);
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/sls_predicate_score.sv -----
`timescale 1ns / 1ps
// Path: neq, and, or, leaf, unused commands and compares already satisfied go from the
// evaluate state straight to the done state; otherwise the item takes k bit-scan steps,
// k <= the clamped bit_width, then the multiply and the serial divider.
// Throughput: one item at a time; the next item can be taken in the cycle after the result
// enters the output register. The bit scan and the serial divider dominate the time per item.
// Reset: synchronous, active low; mismatch_factor returns to 0.5, no result pending.
module sls_predicate_score import slsps_pkg::*; #(
    parameter int MAX_WIDTH = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_command,
    input  logic [63:0]               i_operand_a,
    input  logic [63:0]               i_operand_b,
    input  logic [6:0]                i_bit_width,
    input  logic signed [SCORE_W-1:0] i_child_score_a,
    input  logic signed [SCORE_W-1:0] i_child_score_b,
    input  logic                      i_leaf_value,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SCORE_W-1:0] o_node_score,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW = $clog2(MAX_WIDTH + 2);
    localparam int EW = MW + 1;
    localparam int PW = FACTOR_W + WW;
    localparam int CW = (FRAC_BITS + 2 > 20) ? FRAC_BITS + 2 : 20;

    localparam logic signed [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

    t_state                 r_state, n_state;
    t_ctrl                  ctrl;

    t_cmd                   r_cmd;
    logic [MAX_WIDTH-1:0]   r_a;
    logic [MAX_WIDTH-1:0]   r_b;
    logic [WW-1:0]          r_w;
    logic [IW-1:0]          r_idx;
    logic [MW-1:0]          r_m;
    logic                   r_count_only;
    logic                   r_neg;
    logic signed [SCORE_W-1:0] r_sa;
    logic signed [SCORE_W-1:0] r_sb;
    logic                   r_leaf;
    logic signed [CW-1:0]   r_score;
    logic signed [SCORE_W-1:0] r_node_score;
    logic                   r_out_valid;
    logic [FACTOR_W-1:0]    r_factor;

    logic                   out_free;

    // input width handling
    logic [WW-1:0]          w_in;
    logic [MAX_WIDTH-1:0]   w_mask;

    always_comb begin
        if (i_bit_width == 7'd0) begin
            w_in = WW'(1);
        end else if (i_bit_width > 7'(MAX_WIDTH)) begin
            w_in = WW'(MAX_WIDTH);
        end else begin
            w_in = i_bit_width[WW-1:0];
        end
        w_mask = ~({MAX_WIDTH{1'b1}} << w_in);
    end

    // first look at a registered item
    logic                   a_eq, a_lt;
    logic signed [CW-1:0]   sa_x, sb_x, sum_x, avg_x, min_x, max_x;
    logic                   eval_to_scan;
    logic                   eval_load_xor;
    logic                   eval_count_only;
    logic [MW-1:0]          eval_m_init;
    logic signed [CW-1:0]   eval_score;

    always_comb begin
        a_eq  = r_a == r_b;
        a_lt  = r_a < r_b;
        sa_x  = CW'(r_sa);
        sb_x  = CW'(r_sb);
        sum_x = sa_x + sb_x;
        // halve, truncating toward zero
        avg_x = (sum_x + $signed({{(CW-1){1'b0}}, sum_x[CW-1]})) >>> 1;
        min_x = (sa_x < sb_x) ? sa_x : sb_x;
        max_x = (sa_x > sb_x) ? sa_x : sb_x;

        eval_to_scan    = 1'b0;
        eval_load_xor   = 1'b0;
        eval_count_only = 1'b0;
        eval_m_init     = MW'(1);
        eval_score      = '0;
        case (r_cmd)
            CMD_EQ: begin
                if (a_eq) begin
                    eval_score = ONE_C;
                end else begin
                    eval_to_scan    = 1'b1;
                    eval_load_xor   = 1'b1;
                    eval_count_only = 1'b1;
                    eval_m_init     = '0;
                end
            end
            CMD_NEQ: begin
                eval_score = a_eq ? '0 : ONE_C;
            end
            CMD_ULT: begin
                if (a_lt) begin
                    eval_score = ONE_C;
                end else begin
                    eval_to_scan    = 1'b1;
                    eval_count_only = (r_b == '0);
                end
            end
            CMD_UGE: begin
                if (!a_lt) begin
                    eval_score = ONE_C;
                end else begin
                    eval_to_scan = 1'b1;
                end
            end
            CMD_AND: begin
                if ((avg_x == ONE_C) && ((sa_x < ONE_C) || (sb_x < ONE_C))) begin
                    eval_score = min_x;
                end else begin
                    eval_score = avg_x;
                end
            end
            CMD_OR: begin
                eval_score = max_x;
            end
            CMD_LEAF: begin
                eval_score = r_leaf ? ONE_C : '0;
            end
            default: begin
                eval_score = '0;
            end
        endcase
    end

    // bit scan, one bit per cycle from the top down
    logic                   bit_sel, hit, thresh, stop, scan_last;
    logic [MAX_WIDTH-1:0]   a_next;

    always_comb begin
        bit_sel   = r_a[r_idx];
        hit       = (r_cmd == CMD_UGE) ? !bit_sel : bit_sel;
        a_next    = r_a ^ (MAX_WIDTH'(1) << r_idx);
        thresh    = (r_cmd == CMD_UGE) ? (a_next >= r_b) : (a_next < r_b);
        stop      = hit && !r_count_only && thresh;
        scan_last = stop || (r_idx == '0);
    end

    // factor * (w - m), magnitude and sign
    logic signed [EW-1:0]   d_sig;
    logic                   d_neg;
    logic [EW-1:0]          d_mag;
    logic [PW-1:0]          prod;

    always_comb begin
        d_sig = $signed(EW'(r_w)) - $signed(EW'(r_m));
        d_neg = d_sig[EW-1];
        d_mag = d_neg ? EW'(-d_sig) : EW'(d_sig);
        prod  = PW'(r_factor) * PW'(d_mag[WW-1:0]);
    end

    logic                   div_done;
    logic [PW-1:0]          div_q;
    logic signed [CW-1:0]   q_ext;

    slsps_divider #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (WW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (prod),
        .i_divisor  (r_w),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign q_ext    = $signed(CW'(div_q));
    assign out_free = !r_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EVAL;
            ST_EVAL: n_state = eval_to_scan ? ST_SCAN : ST_DONE;
            ST_SCAN: if (scan_last) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl             = '0;
        ctrl.in_ready    = (r_state == ST_IDLE);
        ctrl.eval        = (r_state == ST_EVAL);
        ctrl.scan        = (r_state == ST_SCAN);
        ctrl.div_start   = (r_state == ST_MUL);
        ctrl.div_capture = (r_state == ST_DIV) && div_done;
        ctrl.out_load    = (r_state == ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_factor    <= FACTOR_RESET;
        end else begin
            r_state <= n_state;
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && (paddr[2] == REG_FACTOR_SEL)) begin
                r_factor <= pwdata[FACTOR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.in_ready && i_in_valid) begin
            r_cmd  <= t_cmd'(i_command);
            r_a    <= i_operand_a[MAX_WIDTH-1:0] & w_mask;
            r_b    <= i_operand_b[MAX_WIDTH-1:0] & w_mask;
            r_w    <= w_in;
            r_idx  <= IW'(w_in - WW'(1));
            r_sa   <= i_child_score_a;
            r_sb   <= i_child_score_b;
            r_leaf <= i_leaf_value;
        end
        if (ctrl.eval) begin
            r_score      <= eval_score;
            r_m          <= eval_m_init;
            r_count_only <= eval_count_only;
            if (eval_load_xor) begin
                r_a <= r_a ^ r_b;
            end
        end
        if (ctrl.scan) begin
            if (hit) begin
                r_m <= r_m + MW'(1);
                if (!r_count_only) begin
                    r_a <= a_next;
                end
            end
            r_idx <= r_idx - IW'(1);
        end
        if (ctrl.div_start) begin
            r_neg <= d_neg;
        end
        if (ctrl.div_capture) begin
            r_score <= r_neg ? -q_ext : q_ext;
        end
        if (ctrl.out_load) begin
            r_node_score <= r_score[SCORE_W-1:0];
        end
    end

    assign o_in_ready   = ctrl.in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_node_score = r_node_score;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_FACTOR_SEL) ? 32'(r_factor) : '0;

endmodule

// ----- tb/tb_sls_predicate_score.sv -----
`timescale 1ns / 1ps

module tb_sls_predicate_score;
    import slsps_pkg::*;

    localparam int          FRAC_BITS   = 16;
    localparam int          MAX_WIDTH   = 64;
    localparam int          ONE_Q       = 1 << FRAC_BITS;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_ITEMS = 180;
    localparam logic [2:0]  CMD_UNUSED  = 3'd7;
    localparam logic [2:0]  FACTOR_ADDR = {REG_FACTOR_SEL, 2'b00};

    typedef struct {
        logic [2:0]                cmd;
        logic [63:0]               a;
        logic [63:0]               b;
        logic [6:0]                width;
        logic signed [SCORE_W-1:0] sa;
        logic signed [SCORE_W-1:0] sb;
        logic                      leaf;
    } t_node;

    typedef struct {
        t_node nd;
        bit    fixed;
        int    score;
    } t_dir_row;

    typedef struct {
        logic [2:0]         cmd;
        logic [SCORE_W-1:0] score;
    } t_score_exp;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [2:0]                i_command;
    logic [63:0]               i_operand_a;
    logic [63:0]               i_operand_b;
    logic [6:0]                i_bit_width;
    logic signed [SCORE_W-1:0] i_child_score_a;
    logic signed [SCORE_W-1:0] i_child_score_b;
    logic                      i_leaf_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [SCORE_W-1:0] o_node_score;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    logic [FACTOR_W-1:0] factor_setting;
    t_score_exp          pending_scores[$];
    t_dir_row            directed_rows[$];
    int                  fail_count  = 0;
    int                  cycle_count = 0;
    int                  burst_left  = 0;
    int                  rcv_mode    = 0;
    int                  rcv_left    = 0;
    bit                  rcv_phase   = 1'b0;

    sls_predicate_score #(
        .MAX_WIDTH(MAX_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_bit_width    (i_bit_width),
        .i_child_score_a(i_child_score_a),
        .i_child_score_b(i_child_score_b),
        .i_leaf_value   (i_leaf_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_node_score   (o_node_score),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint partial_score(input longint fct, input int m, input int w);
        return (fct * longint'(w - m)) / longint'(w);
    endfunction

    function automatic logic [SCORE_W-1:0] predict_score(input t_node nd,
                                                        input logic [FACTOR_W-1:0] factor);
        longint      one;
        longint      sa;
        longint      sb;
        longint      res;
        longint      fct;
        int          w;
        int          m;
        int          i;
        bit          done;
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] cur;
        one = longint'(ONE_Q);
        fct = longint'(factor);
        sa  = nd.sa;
        sb  = nd.sb;
        w   = nd.width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        a    = nd.a & mask;
        b    = nd.b & mask;
        res  = 0;
        case (nd.cmd)
            CMD_EQ: res = (a == b) ? one : partial_score(fct, $countones(a ^ b), w);
            CMD_NEQ: res = (a == b) ? 0 : one;
            CMD_ULT: begin
                if (a < b) begin
                    res = one;
                end else begin
                    if (b == 64'd0) begin
                        m = $countones(a) + 1;
                    end else begin
                        // clear set bits from the top until a drops below b
                        m    = 1;
                        cur  = a;
                        done = 1'b0;
                        for (i = w; i > 0 && !done; i--) begin
                            if (cur[i-1]) begin
                                m++;
                                cur[i-1] = 1'b0;
                                if (cur < b) done = 1'b1;
                            end
                        end
                    end
                    res = partial_score(fct, m, w);
                end
            end
            CMD_UGE: begin
                if (a >= b) begin
                    res = one;
                end else begin
                    m    = 1;
                    cur  = a;
                    done = 1'b0;
                    for (i = w; i > 0 && !done; i--) begin
                        if (!cur[i-1]) begin
                            m++;
                            cur[i-1] = 1'b1;
                            if (cur >= b) done = 1'b1;
                        end
                    end
                    res = partial_score(fct, m, w);
                end
            end
            CMD_AND: begin
                res = (sa + sb) / 2;
                if (res == one && (sa < one || sb < one)) res = (sa < sb) ? sa : sb;
            end
            CMD_OR: res = (sa > sb) ? sa : sb;
            CMD_LEAF: res = nd.leaf ? one : 0;
            default: res = 0;
        endcase
        return res[SCORE_W-1:0];
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [63:0] a, input logic [63:0] b,
                           input int w, input int sa, input int sb, input bit leaf,
                           input bit fixed, input int score);
        t_dir_row row;
        row.nd.cmd   = cmd;
        row.nd.a     = a;
        row.nd.b     = b;
        row.nd.width = w[6:0];
        row.nd.sa    = sa[SCORE_W-1:0];
        row.nd.sb    = sb[SCORE_W-1:0];
        row.nd.leaf  = leaf;
        row.fixed    = fixed;
        row.score    = score;
        directed_rows.push_back(row);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_child();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return SCORE_W'(ONE_Q);
            1: return SCORE_W'(-32768);
            2: return '0;
            3: return SCORE_W'(ONE_Q - 1);
            4: return SCORE_W'($urandom);     // out-of-range noise, full field
            default: return SCORE_W'(int'($urandom_range(0, 98304)) - 32768);
        endcase
    endfunction

    task automatic make_random_node(output t_node nd);
        int r;
        int weff;
        r = $urandom_range(0, 99);
        if (r < 20)      nd.cmd = CMD_EQ;
        else if (r < 30) nd.cmd = CMD_NEQ;
        else if (r < 48) nd.cmd = CMD_ULT;
        else if (r < 66) nd.cmd = CMD_UGE;
        else if (r < 78) nd.cmd = CMD_AND;
        else if (r < 88) nd.cmd = CMD_OR;
        else if (r < 97) nd.cmd = CMD_LEAF;
        else             nd.cmd = CMD_UNUSED;

        r = $urandom_range(0, 99);
        if (r < 3)       nd.width = 7'd0;
        else if (r < 7)  nd.width = 7'($urandom_range(MAX_WIDTH + 1, 127));
        else if (r < 20) nd.width = 7'(MAX_WIDTH);
        else if (r < 45) nd.width = 7'($urandom_range(1, 8));
        else             nd.width = 7'($urandom_range(1, MAX_WIDTH));
        weff = (nd.width < 1) ? 1 : (nd.width > MAX_WIDTH) ? MAX_WIDTH : int'(nd.width);

        nd.a = {$urandom, $urandom};
        nd.b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: nd.b = nd.a;
            1: nd.b = nd.a ^ (64'd1 << $urandom_range(0, weff - 1));
            2: nd.b = nd.a ^ (64'd1 << $urandom_range(0, weff - 1))
                           ^ (64'd1 << $urandom_range(0, weff - 1));
            3: nd.b = 64'd0;
            4: nd.b = '1;
            5: nd.b = nd.a + 64'($urandom_range(1, 4));
            6: nd.b = nd.a - 64'($urandom_range(1, 4));
            7: nd.a = 64'd0;
            8: nd.a = '1;
            default: ;
        endcase

        nd.sa = pick_child();
        nd.sb = pick_child();
        // and: average landing on 1.0 with one child below it
        if (nd.cmd == CMD_AND && $urandom_range(0, 7) == 0)
            nd.sb = SCORE_W'(2 * ONE_Q + int'($urandom_range(0, 1)) - int'(nd.sa));
        nd.leaf = 1'($urandom_range(0, 1));
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_node(input t_node nd, input bit fixed, input int fixed_score);
        int         gap;
        t_score_exp ex;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      = 1'b1;
        i_command       = nd.cmd;
        i_operand_a     = nd.a;
        i_operand_b     = nd.b;
        i_bit_width     = nd.width;
        i_child_score_a = nd.sa;
        i_child_score_b = nd.sb;
        i_leaf_value    = nd.leaf;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        ex.cmd   = nd.cmd;
        ex.score = fixed ? fixed_score[SCORE_W-1:0] : predict_score(nd, factor_setting);
        pending_scores.push_back(ex);
        @(negedge i_clk);
    endtask

    task automatic wait_scores_drained();
        while (pending_scores.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_factor(input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = FACTOR_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        factor_setting = value[FACTOR_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // receiver: stall pattern switches mode every so often
    always @(negedge i_clk) begin
        if (rcv_left == 0) begin
            rcv_mode = $urandom_range(0, 3);
            rcv_left = $urandom_range(20, 200);
        end
        rcv_left--;
        rcv_phase = ~rcv_phase;
        case (rcv_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = 1'($urandom_range(0, 1));
            2: i_out_ready = ($urandom_range(0, 3) == 0);
            default: i_out_ready = rcv_phase;
        endcase
    end

    always @(posedge i_clk) begin
        t_score_exp ex;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected score transfer, got %0d", $time, o_node_score);
                fail_count++;
            end else begin
                ex = pending_scores.pop_front();
                if (o_node_score !== ex.score) begin
                    $display("%0t: node_score mismatch (cmd %0d): expected %0d, actual %0d",
                             $time, ex.cmd, $signed(ex.score), o_node_score);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL sls_predicate_score");
            $finish;
        end
    end

    initial begin
        t_node nd;
        int    phase_factor[NUM_PHASES];
        int    ph;
        int    k;

        phase_factor    = '{32768, 0, 65536, -1, 1, -1, 65535, 32768};
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_EQ;
        i_operand_a     = '0;
        i_operand_b     = '0;
        i_bit_width     = 7'd1;
        i_child_score_a = '0;
        i_child_score_b = '0;
        i_leaf_value    = 1'b0;
        i_out_ready     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        factor_setting  = FACTOR_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed rows, factor at its reset value
        add_row(CMD_EQ,   64'd0, 64'd0, 1, 0, 0, 0, 1, ONE_Q);
        add_row(CMD_EQ,   '1, '1, 64, 0, 0, 0, 1, ONE_Q);
        add_row(CMD_EQ,   '1, 64'd0, 64, 0, 0, 0, 1, 0);       // all bits differ
        add_row(CMD_EQ,   64'd5, 64'd3, 4, 0, 0, 0, 0, 0);
        add_row(CMD_EQ,   64'h100, 64'd0, 8, 0, 0, 0, 1, ONE_Q); // difference above width
        add_row(CMD_EQ,   64'd1, 64'd0, 0, 0, 0, 0, 0, 0);       // zero width
        add_row(CMD_EQ,   '1, 64'd0, 127, 0, 0, 0, 0, 0);        // width over max
        add_row(CMD_NEQ,  64'hDEAD, 64'hDEAD, 16, 0, 0, 0, 1, 0);
        add_row(CMD_NEQ,  64'd1, 64'd0, 64, 0, 0, 0, 1, ONE_Q);
        add_row(CMD_ULT,  64'd1, 64'd2, 8, 0, 0, 0, 1, ONE_Q);
        add_row(CMD_ULT,  '1, 64'd0, 64, 0, 0, 0, 0, 0);         // b zero, negative score
        add_row(CMD_ULT,  64'hFF, 64'h0F, 8, 0, 0, 0, 0, 0);
        add_row(CMD_ULT,  64'h8000_0000_0000_0000, 64'd1, 100, 0, 0, 0, 0, 0);
        add_row(CMD_UGE,  64'hFF, 64'hFF, 8, 0, 0, 0, 1, ONE_Q);
        add_row(CMD_UGE,  64'd0, 64'hFF, 8, 0, 0, 0, 0, 0);
        add_row(CMD_UGE,  64'd0, '1, 64, 0, 0, 0, 0, 0);
        add_row(CMD_AND,  64'd0, 64'd0, 1, ONE_Q, ONE_Q, 0, 1, ONE_Q);
        add_row(CMD_AND,  64'd0, 64'd0, 1, -32768, -32768, 0, 1, -32768);
        add_row(CMD_AND,  64'd0, 64'd0, 1, ONE_Q - 1, ONE_Q + 1, 0, 0, 0); // min fallback
        add_row(CMD_AND,  64'd0, 64'd0, 1, 131071, 131071, 0, 0, 0);
        add_row(CMD_OR,   64'd0, 64'd0, 1, -32768, ONE_Q, 0, 1, ONE_Q);
        add_row(CMD_LEAF, 64'd0, 64'd0, 1, 0, 0, 1, 1, ONE_Q);
        add_row(CMD_LEAF, '1, '1, 64, 0, 0, 0, 1, 0);
        add_row(CMD_UNUSED, '1, 64'd0, 64, ONE_Q, ONE_Q, 1, 1, 0);

        foreach (directed_rows[k])
            send_node(directed_rows[k].nd, directed_rows[k].fixed, directed_rows[k].score);
        i_in_valid = 1'b0;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // every phase boundary also holds the sender until all scores are back
            wait_scores_drained();
            if (ph > 0)
                write_factor((phase_factor[ph] < 0) ? $urandom_range(0, ONE_Q)
                                                    : phase_factor[ph]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                make_random_node(nd);
                send_node(nd, 1'b0, 0);
            end
            i_in_valid = 1'b0;
        end

        wait_scores_drained();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sls_predicate_score");
        end else begin
            $display("FAIL sls_predicate_score");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/slsps_pkg.sv
rtl/core/slsps_divider.sv
rtl/core/sls_predicate_score.sv
tb/tb_sls_predicate_score.sv
